@@ src/smlfr_pkg.sv @@
// Package for the SML transport frame receiver: sizes, command and event codes,
// escape sequences and the structs passed between the controller and the top level.
// No dependencies.
`default_nettype none

package smlfr_pkg;

    localparam int STORE_DEPTH   = 512;
    localparam int START_LENGTH  = 8;
    localparam int END_LENGTH    = 5;
    localparam int TRAILER_BYTES = 3;

    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int FILL_W   = $clog2(STORE_DEPTH + 1);
    localparam int RECENT_W = 8 * END_LENGTH;
    localparam int TICK_W   = 24;
    localparam int LEN_W    = 10;
    localparam int RIDX_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd1;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_DELIVERED = 3'd1;
    localparam logic [2:0] EV_SUPPRESS  = 3'd2;
    localparam logic [2:0] EV_OVERFLOW  = 3'd3;
    localparam logic [2:0] EV_TIMEOUT   = 3'd4;
    localparam logic [2:0] EV_READ      = 3'd5;

    localparam logic [7:0] START_SEQ [8] = '{8'h1B, 8'h1B, 8'h1B, 8'h1B,
                                             8'h01, 8'h01, 8'h01, 8'h01};
    localparam logic [7:0] END_SEQ [8]   = '{8'h1B, 8'h1B, 8'h1B, 8'h1B,
                                             8'h1A, 8'h00, 8'h00, 8'h00};

    // newest byte in the low lane
    function automatic logic [RECENT_W-1:0] end_pattern();
        logic [RECENT_W-1:0] p;
        p = '0;
        for (int k = 0; k < END_LENGTH; k++)
        begin
            p[8*k +: 8] = END_SEQ[END_LENGTH - 1 - k];
        end
        return p;
    endfunction

    localparam logic [RECENT_W-1:0] END_PATTERN = end_pattern();

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [2:0]       event_code;
        logic [LEN_W-1:0] frame_length;
        logic             read_ok;
    } result_t;

endpackage

`default_nettype wire

@@ src/smlfr_if.sv @@
// Valid/ready channel interfaces for the frame receiver: request and result.
// Depends on nothing.
`default_nettype none

interface smlfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [8:0] read_index;

    modport source (output valid, command, data_byte, read_index, input ready);
    modport sink   (input valid, command, data_byte, read_index, output ready);
endinterface

interface smlfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [9:0] frame_length;
    logic [7:0] read_data;

    modport source (output valid, event_res, frame_length, read_data, input ready);
    modport sink   (input valid, event_res, frame_length, read_data, output ready);
endinterface

`default_nettype wire

@@ src/smlfr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module smlfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/smlfr_ctrl.sv @@
// Frame receiver controller: hunt/body/trailer sequencing, end match shift register,
// tick counters and configuration registers. Issues frame store accesses.
// Depends on smlfr_pkg.
`default_nettype none

module smlfr_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [1:0]                     command,
    input  wire logic [7:0]                     data_byte,
    input  wire logic [smlfr_pkg::RIDX_W-1:0]   read_index,
    input  wire logic                           cfg_write_en,
    input  wire logic [smlfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [smlfr_pkg::TICK_W-1:0]   cfg_wdata,
    output smlfr_pkg::mem_req_t                 mem_req,
    output smlfr_pkg::result_t                  result
);

    localparam int FW = smlfr_pkg::FILL_W;
    localparam int RW = smlfr_pkg::RECENT_W;
    localparam int TW = smlfr_pkg::TICK_W;
    localparam int AW = smlfr_pkg::ADDR_W;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_BODY    = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [1:0]    trailer_reg, trailer_next;
    logic [RW-1:0] recent_reg, recent_next;
    logic [TW-1:0] since_restart_reg, since_restart_next;
    logic [TW-1:0] since_delivery_reg, since_delivery_next;
    logic [TW-1:0] timeout_reg, interval_reg;

    logic          hunt_from_zero;
    logic [2:0]    hunt_p;
    logic [RW-1:0] hunt_recent;
    logic [FW-1:0] hunt_fill;
    logic [FW-1:0] body_fill;
    logic [RW-1:0] body_recent;
    logic          overflow;
    logic          end_hit;
    logic          store_room;
    logic [FW-1:0] tr_fill;
    logic [1:0]    tr_left;
    logic          deliver;
    logic [TW-1:0] sr_inc, sd_inc;

    always_comb
    begin
        hunt_from_zero = (phase_reg == PH_BODY);
        hunt_p         = hunt_from_zero ? 3'd0 : fill_reg[2:0];
        hunt_recent    = RW'({(hunt_from_zero ? {RW{1'b0}} : recent_reg), data_byte});
        hunt_fill      = (data_byte == smlfr_pkg::START_SEQ[hunt_p])
                         ? FW'(hunt_p) + FW'(1) : '0;

        body_fill   = fill_reg + FW'(1);
        body_recent = RW'({recent_reg, data_byte});
        overflow    = ({1'b0, fill_reg} + (FW+1)'(smlfr_pkg::TRAILER_BYTES))
                      >= (FW+1)'(smlfr_pkg::STORE_DEPTH);
        end_hit     = (body_fill >= FW'(smlfr_pkg::END_LENGTH))
                      && (body_recent == smlfr_pkg::END_PATTERN);

        store_room = fill_reg < FW'(smlfr_pkg::STORE_DEPTH);
        tr_fill    = store_room ? body_fill : fill_reg;
        tr_left    = (trailer_reg != 2'd0) ? trailer_reg - 2'd1 : 2'd0;
        deliver    = (interval_reg == '0) || (since_delivery_reg > interval_reg);

        sr_inc = (since_restart_reg < smlfr_pkg::TICK_MAX)
                 ? since_restart_reg + TW'(1) : since_restart_reg;
        sd_inc = (since_delivery_reg < smlfr_pkg::TICK_MAX)
                 ? since_delivery_reg + TW'(1) : since_delivery_reg;
    end

    always_comb
    begin
        phase_next          = phase_reg;
        fill_next           = fill_reg;
        trailer_next        = trailer_reg;
        recent_next         = recent_reg;
        since_restart_next  = since_restart_reg;
        since_delivery_next = since_delivery_reg;
        mem_req             = '0;
        result              = '0;
        result.event_code   = smlfr_pkg::EV_NONE;

        unique case (command)
            smlfr_pkg::CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = AW'(hunt_p);
                        mem_req.wdata = data_byte;
                        recent_next   = hunt_recent;
                        fill_next     = hunt_fill;
                        if (hunt_fill >= FW'(smlfr_pkg::START_LENGTH))
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = data_byte;
                        if (overflow)
                        begin
                            // restart, then treat this byte as the first hunt byte
                            result.event_code = smlfr_pkg::EV_OVERFLOW;
                            since_restart_next = '0;
                            trailer_next  = 2'(smlfr_pkg::TRAILER_BYTES);
                            mem_req.waddr = AW'(hunt_p);
                            recent_next   = hunt_recent;
                            fill_next     = hunt_fill;
                            phase_next    = (hunt_fill >= FW'(smlfr_pkg::START_LENGTH))
                                            ? PH_BODY : PH_HUNT;
                        end
                        else
                        begin
                            mem_req.waddr = AW'(fill_reg);
                            fill_next     = body_fill;
                            recent_next   = body_recent;
                            if (end_hit)
                            begin
                                phase_next   = PH_TRAILER;
                                trailer_next = 2'(smlfr_pkg::TRAILER_BYTES);
                            end
                        end
                    end
                    default:
                    begin
                        mem_req.we    = store_room;
                        mem_req.waddr = AW'(fill_reg);
                        mem_req.wdata = data_byte;
                        fill_next     = tr_fill;
                        trailer_next  = tr_left;
                        if (tr_left == 2'd0)
                        begin
                            result.frame_length = smlfr_pkg::LEN_W'(tr_fill);
                            if (deliver)
                            begin
                                result.event_code   = smlfr_pkg::EV_DELIVERED;
                                since_delivery_next = '0;
                            end
                            else
                            begin
                                result.event_code = smlfr_pkg::EV_SUPPRESS;
                            end
                            phase_next         = PH_HUNT;
                            fill_next          = '0;
                            trailer_next       = 2'(smlfr_pkg::TRAILER_BYTES);
                            recent_next        = '0;
                            since_restart_next = '0;
                        end
                    end
                endcase
            end
            smlfr_pkg::CMD_TICK:
            begin
                since_restart_next  = sr_inc;
                since_delivery_next = sd_inc;
                if (sr_inc > timeout_reg)
                begin
                    result.event_code  = smlfr_pkg::EV_TIMEOUT;
                    phase_next         = PH_HUNT;
                    fill_next          = '0;
                    trailer_next       = 2'(smlfr_pkg::TRAILER_BYTES);
                    recent_next        = '0;
                    since_restart_next = '0;
                end
            end
            smlfr_pkg::CMD_READ:
            begin
                result.event_code = smlfr_pkg::EV_READ;
                result.read_ok    = 32'(read_index) < 32'(smlfr_pkg::STORE_DEPTH);
                mem_req.re        = 1'b1;
                mem_req.raddr     = AW'(read_index);
            end
            smlfr_pkg::CMD_NOP:
            begin
                result.event_code = smlfr_pkg::EV_NONE;
            end
        endcase

        if (!accept)
        begin
            mem_req.we = 1'b0;
            mem_req.re = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            fill_reg           <= '0;
            trailer_reg        <= 2'(smlfr_pkg::TRAILER_BYTES);
            recent_reg         <= '0;
            since_restart_reg  <= '0;
            since_delivery_reg <= '0;
            timeout_reg        <= smlfr_pkg::TIMEOUT_RESET;
            interval_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg          <= phase_next;
                fill_reg           <= fill_next;
                trailer_reg        <= trailer_next;
                recent_reg         <= recent_next;
                since_restart_reg  <= since_restart_next;
                since_delivery_reg <= since_delivery_next;
            end
            if (cfg_write_en)
            begin
                if (cfg_index == smlfr_pkg::REG_TIMEOUT)
                begin
                    timeout_reg <= cfg_wdata;
                end
                if (cfg_index == smlfr_pkg::REG_INTERVAL)
                begin
                    interval_reg <= cfg_wdata;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sml_frame_receiver.sv @@
// Top level of the SML transport frame receiver: controller, frame store RAM and
// result register. Depends on smlfr_pkg, smlfr_if, smlfr_ram and smlfr_ctrl.
`default_nettype none

// Takes one transaction per cycle (byte, tick, read or no-op) and returns exactly
// one result transaction for each. All framing state is updated in the accepting
// cycle; the 512-byte frame store is a RAM with a registered read port, whose data
// lands with the result register in the cycle after acceptance. A held result
// stalls the input only while the result is not taken. There is no clearing pass
// after reset: stored bytes are undefined until written. Configuration writes must
// be issued while no transaction is in flight.
module sml_frame_receiver (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    smlfr_req_if.sink                             req,
    smlfr_rsp_if.source                           rsp,
    input  wire logic                             cfg_write_en,
    input  wire logic [smlfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smlfr_pkg::TICK_W-1:0]     cfg_wdata
);

    logic                accept;
    smlfr_pkg::mem_req_t mem_req;
    smlfr_pkg::result_t  result;
    smlfr_pkg::result_t  result_reg;
    logic                out_valid_reg;
    logic [7:0]          ram_rdata;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    smlfr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (req.command),
        .data_byte    (req.data_byte),
        .read_index   (req.read_index),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mem_req      (mem_req),
        .result       (result)
    );

    smlfr_ram #(
        .WIDTH (8),
        .DEPTH (smlfr_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.event_res    = result_reg.event_code;
    assign rsp.frame_length = result_reg.frame_length;
    assign rsp.read_data    = (result_reg.event_code == smlfr_pkg::EV_READ
                               && result_reg.read_ok) ? ram_rdata : 8'd0;

endmodule

`default_nettype wire

@@ src/smlfr_checker.sv @@
// Port-level assertions for sml_frame_receiver and the bind that attaches them.
// Depends on smlfr_pkg and sml_frame_receiver.
`default_nettype none

module smlfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [2:0] event_res,
    input wire logic [9:0] frame_length,
    input wire logic [7:0] read_data
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted transaction produced no result");

    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && event_res != smlfr_pkg::EV_READ |-> read_data == 8'd0)
        else $error("read_data set outside a read result");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && event_res != smlfr_pkg::EV_DELIVERED
        && event_res != smlfr_pkg::EV_SUPPRESS |-> frame_length == 10'd0)
        else $error("frame_length set outside a frame result");

    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (event_res == smlfr_pkg::EV_DELIVERED
        || event_res == smlfr_pkg::EV_SUPPRESS)
        |-> frame_length >= 10'(smlfr_pkg::END_LENGTH + smlfr_pkg::TRAILER_BYTES))
        else $error("frame shorter than end sequence plus trailer");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res)
        && $stable(frame_length) && $stable(read_data))
        else $error("stalled result changed");

endmodule

bind sml_frame_receiver smlfr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .event_res    (rsp.event_res),
    .frame_length (rsp.frame_length),
    .read_data    (rsp.read_data)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for sml_frame_receiver: directed and random byte, tick,
// read and no-op transactions, checked against an in-bench model of the framing.
// Depends on smlfr_pkg, smlfr_if and the RTL of sml_frame_receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smlfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {RX_HUNT, RX_BODY, RX_TRAILER} rx_phase_t;

    typedef struct packed {
        logic [2:0]       ev;
        logic [LEN_W-1:0] len;
        logic [7:0]       rd;
    } outcome_t;

    class frame_scoreboard;
        logic [TICK_W-1:0]   timeout_ticks;
        logic [TICK_W-1:0]   interval_ticks;
        rx_phase_t           phase;
        int unsigned         fill;
        int unsigned         trailer_left;
        logic [RECENT_W-1:0] recent;
        logic [TICK_W-1:0]   since_restart;
        logic [TICK_W-1:0]   since_delivery;
        logic [7:0]          frame_store [STORE_DEPTH];
        bit                  written [STORE_DEPTH];
        int unsigned         written_list [$];
        outcome_t            outcomes_due [$];
        int                  mismatches;
        int                  n_items;
        int                  n_event [8];

        function new();
            timeout_ticks  = TIMEOUT_RESET;
            interval_ticks = '0;
            since_delivery = '0;
            mismatches     = 0;
            n_items        = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                frame_store[i] = 8'h00;
                written[i]     = 1'b0;
            end
            for (int i = 0; i < 8; i++)
            begin
                n_event[i] = 0;
            end
            restart();
        endfunction

        function void restart();
            phase         = RX_HUNT;
            fill          = 0;
            trailer_left  = TRAILER_BYTES;
            recent        = '0;
            since_restart = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] value);
            if (idx == REG_TIMEOUT)
                timeout_ticks = value;
            else if (idx == REG_INTERVAL)
                interval_ticks = value;
        endfunction

        function void store_byte(int unsigned idx, logic [7:0] b);
            frame_store[idx] = b;
            if (!written[idx])
            begin
                written[idx] = 1'b1;
                written_list.push_back(idx);
            end
        endfunction

        function void hunt_byte(logic [7:0] b);
            int unsigned p;
            p = fill % 8;
            store_byte(p, b);
            recent = {recent[RECENT_W-9:0], b};
            if (b == START_SEQ[p])
                fill = p + 1;
            else
                fill = 0;
            if (fill >= START_LENGTH)
                phase = RX_BODY;
        endfunction

        function void take_item(logic [1:0] cmd, logic [7:0] b, logic [RIDX_W-1:0] ridx);
            outcome_t o;
            o = '0;
            o.ev = EV_NONE;
            case (cmd)
                CMD_BYTE:
                begin
                    if (phase == RX_HUNT)
                    begin
                        hunt_byte(b);
                    end
                    else if (phase == RX_BODY)
                    begin
                        if (fill + TRAILER_BYTES >= STORE_DEPTH)
                        begin
                            restart();
                            o.ev = EV_OVERFLOW;
                            hunt_byte(b);
                        end
                        else
                        begin
                            store_byte(fill, b);
                            fill++;
                            recent = {recent[RECENT_W-9:0], b};
                            if (fill >= END_LENGTH && recent == END_PATTERN)
                            begin
                                phase        = RX_TRAILER;
                                trailer_left = TRAILER_BYTES;
                            end
                        end
                    end
                    else
                    begin
                        if (fill < STORE_DEPTH)
                        begin
                            store_byte(fill, b);
                            fill++;
                        end
                        if (trailer_left > 0)
                            trailer_left--;
                        if (trailer_left == 0)
                        begin
                            o.len = fill[LEN_W-1:0];
                            if (interval_ticks == 0 || since_delivery > interval_ticks)
                            begin
                                o.ev           = EV_DELIVERED;
                                since_delivery = '0;
                            end
                            else
                            begin
                                o.ev = EV_SUPPRESS;
                            end
                            restart();
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (since_restart != TICK_MAX)
                        since_restart++;
                    if (since_delivery != TICK_MAX)
                        since_delivery++;
                    if (since_restart > timeout_ticks)
                    begin
                        restart();
                        o.ev = EV_TIMEOUT;
                    end
                end
                CMD_READ:
                begin
                    o.ev = EV_READ;
                    if (ridx < STORE_DEPTH)
                        o.rd = frame_store[ridx];
                end
                default:
                begin
                    o.ev = EV_NONE;
                end
            endcase
            n_items++;
            n_event[o.ev]++;
            outcomes_due.push_back(o);
        endfunction

        task report(input string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_outcome(input logic [2:0] ev, input logic [LEN_W-1:0] len,
                           input logic [7:0] rd);
            outcome_t want;
            if (outcomes_due.size() == 0)
            begin
                report($sformatf("result transaction with nothing due, event %0d", ev));
                return;
            end
            want = outcomes_due.pop_front();
            if (ev !== want.ev)
                report($sformatf("event_res %0d, want %0d", ev, want.ev));
            if (len !== want.len)
                report($sformatf("frame_length %0d, want %0d", len, want.len));
            if (rd !== want.rd)
                report($sformatf("read_data %02h, want %02h", rd, want.rd));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0] cfg_wdata;
    int idle_pct = 9;
    int items_sent = 0;
    int cycle_count = 0;

    frame_scoreboard sb = new();

    smlfr_req_if req_ch ();
    smlfr_rsp_if rsp_ch ();

    sml_frame_receiver i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_outcome(rsp_ch.event_res, rsp_ch.frame_length, rsp_ch.read_data);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.outcomes_due.size());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [RIDX_W-1:0] idx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.data_byte  <= b;
        req_ch.read_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.take_item(cmd, b, idx);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b, RIDX_W'($urandom_range(0, 511)));
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom_range(0, 255)), RIDX_W'($urandom_range(0, 511)));
    endtask

    task automatic send_nop();
        send_item(CMD_NOP, 8'($urandom_range(0, 255)), RIDX_W'($urandom_range(0, 511)));
    endtask

    // reads only ever target store entries that have been written
    task automatic send_read();
        int unsigned n;
        n = sb.written_list.size();
        if (n == 0)
            send_nop();
        else
            send_item(CMD_READ, 8'($urandom_range(0, 255)),
                      RIDX_W'(sb.written_list[$urandom_range(0, n - 1)]));
    endtask

    task automatic side_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            send_tick();
        else if (r < 8)
            send_read();
        else if (r < 10)
            send_nop();
    endtask

    task automatic send_frame(input int body_len, input bit with_end);
        for (int k = 0; k < START_LENGTH; k++)
            send_byte(START_SEQ[k]);
        for (int k = 0; k < body_len; k++)
        begin
            side_item();
            send_byte(($urandom_range(0, 7) == 0) ? 8'h1B : 8'($urandom_range(0, 255)));
        end
        if (with_end)
        begin
            for (int k = 0; k < END_LENGTH; k++)
                send_byte(END_SEQ[k]);
            for (int k = 0; k < TRAILER_BYTES; k++)
            begin
                side_item();
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random(input int budget, input int long_pct);
        int stop;
        int r;
        int body_len;
        int n_start;
        stop = items_sent + budget;
        while (items_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < long_pct)
                body_len = $urandom_range(200, 320);
            else
                body_len = $urandom_range(0, 24);
            if (r < 55)
            begin
                send_frame(body_len, 1'b1);
            end
            else if (r < 62)
            begin
                send_frame(body_len, 1'b0);
            end
            else if (r < 70)
            begin
                n_start = $urandom_range(1, START_LENGTH - 1);
                for (int k = 0; k < n_start; k++)
                    send_byte(START_SEQ[k]);
                send_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 90)
            begin
                repeat ($urandom_range(1, 6))
                    send_tick();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_read();
                send_nop();
            end
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.outcomes_due.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic new_setting(input logic [TICK_W-1:0] timeout, input logic [TICK_W-1:0] interval);
        drain();
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_INTERVAL, interval);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_write_en      = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_NOP;
        req_ch.data_byte  = 8'h00;
        req_ch.read_index = '0;
        rsp_ch.ready      = 1'b0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset register values; start mismatch, then one delivered frame with a one-byte body
        send_nop();
        for (int k = 0; k < 5; k++)
            send_byte(8'h1B);
        send_tick();
        for (int k = 0; k < START_LENGTH; k++)
            send_byte(START_SEQ[k]);
        send_byte(8'hFF);
        for (int k = 0; k < END_LENGTH; k++)
            send_byte(END_SEQ[k]);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_item(CMD_READ, 8'h00, '0);
        send_item(CMD_READ, 8'hFF, RIDX_W'(START_LENGTH + 1 + END_LENGTH + 2));
        run_random(15, 0);

        // timeout of one tick: ticks restart the receiver
        new_setting(24'd1, 24'd0);
        send_tick();
        send_tick();
        run_random(20, 0);

        new_setting(24'd40, 24'd3);
        run_random(35, 0);

        // largest settings: no timeout, every frame suppressed
        new_setting(TICK_MAX, TICK_MAX);
        run_random(15, 0);

        // store overflow, no idling on either side
        new_setting(24'd5000, 24'd0);
        idle_pct = 0;
        for (int k = 0; k < START_LENGTH; k++)
            send_byte(START_SEQ[k]);
        repeat (STORE_DEPTH - START_LENGTH - 4)
            send_byte(8'($urandom_range(0, 255)));
        repeat (8)
            send_read();
        run_random(15, 0);
        idle_pct = 9;

        drain();
        repeat (8)
            @(negedge clk);
        if (sb.outcomes_due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outcomes_due.size()));
        $display("Ran %0d transactions in %0d cycles: %0d delivered, %0d suppressed,",
                 sb.n_items, cycle_count, sb.n_event[EV_DELIVERED], sb.n_event[EV_SUPPRESS]);
        $display("  %0d overflow restarts, %0d timeout restarts, %0d reads, %0d mismatches",
                 sb.n_event[EV_OVERFLOW], sb.n_event[EV_TIMEOUT], sb.n_event[EV_READ],
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

@@ files.f @@
src/smlfr_pkg.sv
src/smlfr_if.sv
src/smlfr_ram.sv
src/smlfr_ctrl.sv
src/sml_frame_receiver.sv
src/smlfr_checker.sv
tb/tb_top.sv
